### src/sem_pkg.sv
// shared types, constants and helpers of the sobel edge magnitude block
`default_nettype none
package sem_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   localparam int CFG_W   = 11;
   localparam int ROW_W   = 11;
   localparam int PIX_W   = 8;
   localparam int COLS_W  = 10;
   localparam int GRAD_W  = 11;
   localparam int SUM_W   = 21;
   localparam int SQ_W    = 16;
   localparam int LANES   = 3;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
   localparam logic [SUM_W-1:0] SAT_LIMIT    = 21'd65281;
   localparam logic [PIX_W-1:0] EDGE_MAX     = 8'd255;
   localparam logic [PIX_W-1:0] ROOT_FIRST   = 8'h80;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic [0:0] {
      F_IDLE  = 1'b0,
      F_WRITE = 1'b1
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE   = 3'd0,
      B_GRAD   = 3'd1,
      B_SQUARE = 3'd2,
      B_ROOT   = 3'd3,
      B_OUT    = 3'd4
   } back_state_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_red;
      logic [PIX_W-1:0] pixel_green;
      logic [PIX_W-1:0] pixel_blue;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_red;
      logic [PIX_W-1:0] edge_green;
      logic [PIX_W-1:0] edge_blue;
      logic             last_of_run;
      logic             last_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type top;
      rgb_type mid;
      rgb_type bot;
   } column_type;

   typedef struct packed {
      column_type left;
      column_type mid;
      column_type cur;
      logic       emit_a;
      logic       emit_b;
      logic       last_frame;
   } job_type;

   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
   } cfg_type;

   function automatic logic [PIX_W-1:0] chan(input rgb_type p, input int ch);
      logic [PIX_W-1:0] v;
      case (ch)
         0: v = p.red;
         1: v = p.green;
         default: v = p.blue;
      endcase
      return v;
   endfunction

   // top + 2*mid + bottom of one channel
   function automatic logic [COLS_W-1:0] tap_sum(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
      return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
   endfunction

endpackage
`default_nettype wire

### src/sem_ram.sv
// generic single write port ram with registered read
`default_nettype none
module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

### src/sem_front.sv
// front end: raster position, line stores and column window, builds jobs
`default_nettype none
module sem_front #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire sem_pkg::cfg_type         cfg,
   input  wire logic                     cfg_write,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire sem_pkg::req_payload_type req_data,
   input  wire logic                     queue_full,
   output logic                          push,
   output sem_pkg::job_type              push_data
);
   import sem_pkg::*;

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int LINE_W = 3 * PIX_W;

   front_state_type state_ff, state_in;
   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   column_type       win0_ff, win0_in, win1_ff, win1_in;
   rgb_type          pix_ff, pix_in;
   logic [AW-1:0]    cuse_ff, cuse_in;
   logic [ROW_W-1:0] ruse_ff, ruse_in;
   logic             lastc_ff, lastc_in;

   logic [CFG_W-1:0] w_eff, h_eff;
   logic [AW-1:0]    c_now;
   logic [ROW_W-1:0] r_now;
   logic             accept;
   rgb_type          upper_rd, lower_rd;
   column_type       cur;
   logic             wr_en;

   always_comb begin
      if (cfg.width == '0) w_eff = CFG_W'(1);
      else if (int'(cfg.width) > MAX_WIDTH) w_eff = CFG_W'(MAX_WIDTH);
      else w_eff = cfg.width;
      if (cfg.height == '0) h_eff = CFG_W'(1);
      else if (int'(cfg.height) > MAX_HEIGHT) h_eff = CFG_W'(MAX_HEIGHT);
      else h_eff = cfg.height;
   end

   assign c_now  = (int'(col_ff) >= int'(w_eff)) ? '0 : col_ff;
   assign r_now  = (row_ff > h_eff) ? '0 : row_ff;
   assign accept = req_valid && req_ready;

   sem_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH), .AW(AW)) upper_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cuse_ff),
      .wr_data (lower_rd),
      .rd_en   (accept),
      .rd_addr (c_now),
      .rd_data (upper_rd)
   );

   sem_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH), .AW(AW)) lower_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cuse_ff),
      .wr_data (cur.bot),
      .rd_en   (accept),
      .rd_addr (c_now),
      .rd_data (lower_rd)
   );

   always_comb begin
      // rows above the frame read as zero, the flush row supplies zeros
      cur.top = (ruse_ff >= ROW_W'(2)) ? upper_rd : '0;
      cur.mid = (ruse_ff >= ROW_W'(1)) ? lower_rd : '0;
      cur.bot = (ruse_ff < h_eff) ? pix_ff : '0;
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      win0_in   = win0_ff;
      win1_in   = win1_ff;
      pix_in    = pix_ff;
      cuse_in   = cuse_ff;
      ruse_in   = ruse_ff;
      lastc_in  = lastc_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      push      = 1'b0;
      push_data.left       = win0_ff;
      push_data.mid        = win1_ff;
      push_data.cur        = cur;
      push_data.emit_a     = (cuse_ff != '0);
      push_data.emit_b     = lastc_ff;
      push_data.last_frame = (ruse_ff == h_eff);
      case (state_ff)
         F_IDLE: begin
            req_ready = !queue_full;
            if (accept) begin
               pix_in   = rgb_type'(req_data);
               cuse_in  = c_now;
               ruse_in  = r_now;
               lastc_in = (int'(c_now) + 1 >= int'(w_eff));
               state_in = F_WRITE;
            end
         end
         F_WRITE: begin
            wr_en = 1'b1;
            push  = (ruse_ff != '0) && ((cuse_ff != '0) || lastc_ff);
            if (lastc_ff) begin
               win0_in = '0;
               win1_in = '0;
               col_in  = '0;
               row_in  = (ruse_ff >= h_eff) ? '0 : ruse_ff + ROW_W'(1);
            end else begin
               win0_in = win1_ff;
               win1_in = cur;
               col_in  = cuse_ff + AW'(1);
               row_in  = ruse_ff;
            end
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
      if (cfg_write) begin
         col_in  = '0;
         row_in  = '0;
         win0_in = '0;
         win1_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         win0_ff  <= '0;
         win1_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         win0_ff  <= win0_in;
         win1_ff  <= win1_in;
      end
      pix_ff   <= pix_in;
      cuse_ff  <= cuse_in;
      ruse_ff  <= ruse_in;
      lastc_ff <= lastc_in;
   end

   a_accept_then_write: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == F_WRITE)
      else $error("front did not move to the store update after a transaction");

endmodule
`default_nettype wire

### src/sem_queue.sv
// two entry job queue between front and back
`default_nettype none
module sem_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire sem_pkg::job_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  head_valid,
   output sem_pkg::job_type      head
);
   import sem_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 2'd1;
      else if (pop && !push) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("job pushed into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");

endmodule
`default_nettype wire

### src/sem_back.sv
// back end: gradients, squares, iterative rounded square root, output register
`default_nettype none
module sem_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire sem_pkg::job_type         head,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output sem_pkg::rsp_payload_type      rsp_data
);
   import sem_pkg::*;

   back_state_type state_ff, state_in;
   logic           sel_ff, sel_in;
   logic signed [GRAD_W-1:0] gx_ff [LANES];
   logic signed [GRAD_W-1:0] gy_ff [LANES];
   logic [SUM_W-1:0] sum_ff [LANES];
   logic [PIX_W-1:0] root_ff [LANES];
   logic [PIX_W-1:0] root_in [LANES];
   logic [PIX_W-1:0] bit_ff, bit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   column_type l_col, m_col, r_col;
   logic signed [GRAD_W-1:0] gx [LANES];
   logic signed [GRAD_W-1:0] gy [LANES];
   logic [SUM_W-1:0] sum [LANES];
   logic [PIX_W-1:0] edge_val [LANES];
   logic             out_free;

   // column triple: the emit_a result uses left/mid/cur, the emit_b result mid/cur/zero
   always_comb begin
      l_col = sel_ff ? head.mid : head.left;
      m_col = sel_ff ? head.cur : head.mid;
      r_col = sel_ff ? '0 : head.cur;
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         logic [COLS_W-1:0] sr, sl, sb, st;
         logic signed [2*GRAD_W-1:0] qx, qy;
         logic [PIX_W-1:0] t;
         logic [SQ_W-1:0] tt, nn;
         sr = tap_sum(chan(r_col.top, i), chan(r_col.mid, i), chan(r_col.bot, i));
         sl = tap_sum(chan(l_col.top, i), chan(l_col.mid, i), chan(l_col.bot, i));
         sb = tap_sum(chan(l_col.bot, i), chan(m_col.bot, i), chan(r_col.bot, i));
         st = tap_sum(chan(l_col.top, i), chan(m_col.top, i), chan(r_col.top, i));
         gx[i] = $signed({1'b0, sr}) - $signed({1'b0, sl});
         gy[i] = $signed({1'b0, sb}) - $signed({1'b0, st});
         qx = gx_ff[i] * gx_ff[i];
         qy = gy_ff[i] * gy_ff[i];
         sum[i] = SUM_W'(qx) + SUM_W'(qy);
         // one bit of the root per cycle
         t  = root_ff[i] | bit_ff;
         tt = t * t;
         root_in[i] = ({5'b0, tt} <= sum_ff[i]) ? t : root_ff[i];
         // round to nearest: up when s > n*n + n
         nn = root_ff[i] * root_ff[i];
         if (sum_ff[i] >= SAT_LIMIT) edge_val[i] = EDGE_MAX;
         else if (sum_ff[i] > ({5'b0, nn} + {13'b0, root_ff[i]}))
            edge_val[i] = root_ff[i] + PIX_W'(1);
         else edge_val[i] = root_ff[i];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (head_valid) begin
               sel_in   = !head.emit_a;
               state_in = B_GRAD;
            end
         end
         B_GRAD:   state_in = B_SQUARE;
         B_SQUARE: begin
            bit_in   = ROOT_FIRST;
            state_in = B_ROOT;
         end
         B_ROOT: begin
            bit_in = bit_ff >> 1;
            if (bit_ff[0]) state_in = B_OUT;
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.edge_red      = edge_val[0];
               rsp_data_in.edge_green    = edge_val[1];
               rsp_data_in.edge_blue     = edge_val[2];
               rsp_data_in.last_of_run   = sel_ff || !head.emit_b;
               rsp_data_in.last_of_frame = sel_ff && head.last_frame;
               if (!sel_ff && head.emit_b) begin
                  sel_in   = 1'b1;
                  state_in = B_GRAD;
               end else begin
                  pop      = 1'b1;
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      bit_ff      <= bit_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < LANES; i++) begin
         if (state_ff == B_GRAD) begin
            gx_ff[i] <= gx[i];
            gy_ff[i] <= gy[i];
         end
         if (state_ff == B_SQUARE) begin
            sum_ff[i]  <= sum[i];
            root_ff[i] <= '0;
         end else if (state_ff == B_ROOT) begin
            root_ff[i] <= root_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_root_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_ROOT |-> $onehot(bit_ff))
      else $error("root trial bit is not one-hot");

   a_frame_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last_of_frame |-> rsp_data_ff.last_of_run)
      else $error("frame end flagged on a result that does not end its run");

endmodule
`default_nettype wire

### src/sobel_edge_magnitude.sv
// top level of the sobel edge magnitude block with its register port
// usage:
//   req channel: one raster rgb pixel per transaction (valid/ready); after
//   image_height rows send one more row of image_width dummy transactions
//   to flush the last row
//   rsp channel: one gradient magnitude per pixel (valid/ready), one row and
//   one column behind the input; last_of_run marks the final result of an
//   input transaction, last_of_frame the bottom-right pixel
//   register port: apb-style, image_width at 0x0, image_height at 0x4;
//   a write restarts the frame (line stores keep their contents)
// processing:
//   the front end accepts a pixel (line store read), then writes the line
//   stores back before it takes the next one; the back end handles a job
//   in order: idle pickup, gradient, square, 8 root iterations, rounding,
//   and repeats gradient through rounding for the second result of the
//   last column, with the three colors in parallel lanes; the back end
//   takes no new job until it is through with the current one
// reset: synchronous, clears position, window, queue and output valid;
//   registers return to 640 x 480; line stores are not cleared
// stall: a result waits in the output register; the back end and then the
//   two-entry job queue fill up before req_ready drops
`default_nettype none
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire sem_pkg::req_payload_type         req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output sem_pkg::rsp_payload_type              rsp_data,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [sem_pkg::ADDR_W-1:0]       paddr,
   input  wire logic [sem_pkg::DATA_W-1:0]       pwdata,
   output logic      [sem_pkg::DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import sem_pkg::*;

   // configuration registers
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             cfg_write;
   reg_index_type    reg_index;
   cfg_type          cfg;

   // front to queue and queue to back
   logic    push, queue_full, pop, head_valid;
   job_type push_data, head;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[2]);
   // write completes in the access phase
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_IMAGE_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (reg_index)
         REG_IMAGE_WIDTH:  prdata = {{(DATA_W-CFG_W){1'b0}}, width_ff};
         REG_IMAGE_HEIGHT: prdata = {{(DATA_W-CFG_W){1'b0}}, height_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

   // front: raster position, line stores, column window
   sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_write  (cfg_write),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decouples the pixel side from the arithmetic side
   sem_queue queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // back: one or two results per job
   sem_back back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
